// File: src/catmull_rom_interpolator_assert.svh
// assertion macros for the catmull-rom interpolator
// no dependencies; included by modules that carry assertions
`ifndef CATMULL_ROM_INTERPOLATOR_ASSERT_SVH
`define CATMULL_ROM_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define CRM_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("catmull-rom assertion failed");
// expression must never be true at a clock edge out of reset
`define CRM_ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("catmull-rom forbidden condition seen");
`else
`define CRM_ASSERT(name, clk, rst_n, prop)
`define CRM_ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

// File: src/crm_pkg.sv
// shared widths, constants and types for the catmull-rom interpolator
// no dependencies
package crm_pkg;

	// coordinate and parameter formats
	localparam int COORD_BITS      = 16;
	localparam int PARAM_FRAC_BITS = 16;
	localparam int PARAM_W         = PARAM_FRAC_BITS + 1;

	// t^2 and t^3 products before rounding
	localparam int SQ_W = 2 * PARAM_W;

	// doubled weights stay below 2^(F+3) in magnitude
	localparam int WGT_W  = PARAM_FRAC_BITS + 5;
	localparam int PROD_W = COORD_BITS + WGT_W;
	localparam int ACC_W  = PROD_W + 3;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = ((8 * COORD_BITS + PARAM_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

	localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC_BITS;

	// four doubled basis weights in units of 2^-F
	typedef struct packed {
		logic signed [WGT_W-1:0] w1;
		logic signed [WGT_W-1:0] w2;
		logic signed [WGT_W-1:0] w3;
		logic signed [WGT_W-1:0] w4;
	} weights_t;

	// one coordinate of the four control points
	typedef struct packed {
		logic signed [COORD_BITS-1:0] p0;
		logic signed [COORD_BITS-1:0] p1;
		logic signed [COORD_BITS-1:0] p2;
		logic signed [COORD_BITS-1:0] p3;
	} coord4_t;

endpackage

// File: src/crm_weights.sv
// basis weight pipeline: t clamp, t^2, t^3 and the four doubled weights
// depends on crm_pkg; t passes the square, round and cube stages before the weights are registered
module crm_weights
	import crm_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [PARAM_W-1:0] t,
	output weights_t           wgt
);

	localparam logic [SQ_W-1:0] HALF = SQ_W'(1) << (PARAM_FRAC_BITS - 1);

	logic [PARAM_W-1:0] t_clamp;
	logic [PARAM_W-1:0] t_s1, t_s2, t_s3;
	logic [SQ_W-1:0]    sq_s1, cu_s3;
	logic [PARAM_W-1:0] t2_s2, t2_s3;
	logic [SQ_W-1:0]    sq_rnd, cu_rnd;
	logic [PARAM_W-1:0] t3_val;
	logic signed [WGT_W-1:0] tw, t2w, t3w, two_s;
	weights_t           wgt_s4;

	// values above one are taken as one
	assign t_clamp = (t > PARAM_ONE) ? PARAM_ONE : t;

	// rounding of the square and the cube, ties upward
	assign sq_rnd = sq_s1 + HALF;
	assign cu_rnd = cu_s3 + HALF;
	assign t3_val = cu_rnd[PARAM_FRAC_BITS +: PARAM_W];

	// stage 1: square
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= t_clamp;
			sq_s1 <= SQ_W'(t_clamp) * SQ_W'(t_clamp);
		end
	end

	// stage 2: round square
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2  <= t_s1;
			t2_s2 <= sq_rnd[PARAM_FRAC_BITS +: PARAM_W];
		end
	end

	// stage 3: cube
	always_ff @(posedge clk) begin
		if (en) begin
			t_s3  <= t_s2;
			t2_s3 <= t2_s2;
			cu_s3 <= SQ_W'(t2_s2) * SQ_W'(t_s2);
		end
	end

	// signed views of the powers of t
	assign tw    = signed'(WGT_W'(t_s3));
	assign t2w   = signed'(WGT_W'(t2_s3));
	assign t3w   = signed'(WGT_W'(t3_val));
	assign two_s = signed'(WGT_W'(1) << (PARAM_FRAC_BITS + 1));

	// stage 4: doubled weights
	always_ff @(posedge clk) begin
		if (en) begin
			wgt_s4.w1 <= (t2w <<< 1) - t3w - tw;
			wgt_s4.w2 <= (t3w <<< 1) + t3w - (t2w <<< 2) - t2w + two_s;
			wgt_s4.w3 <= (t2w <<< 2) + tw - (t3w <<< 1) - t3w;
			wgt_s4.w4 <= t3w - t2w;
		end
	end

	assign wgt = wgt_s4;

endmodule

// File: src/crm_blend.sv
// one-axis blend: weighted sum of four coordinates, rounding, saturation
// depends on crm_pkg; points delayed to meet weights from crm_weights
module crm_blend
	import crm_pkg::*;
(
	input  logic                         clk,
	input  logic                         en,
	input  coord4_t                      pts,
	input  weights_t                     wgt,
	output logic signed [COORD_BITS-1:0] res
);

	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ROUND =
		signed'(ACC_W'(1) << PARAM_FRAC_BITS);

	coord4_t pts_s1, pts_s2, pts_s3, pts_s4;
	logic signed [PROD_W-1:0]     prod0_s5, prod1_s5, prod2_s5, prod3_s5;
	logic signed [ACC_W-1:0]      acc_s6;
	logic signed [ACC_W-1:0]      shifted;
	logic signed [COORD_BITS-1:0] res_s7;

	// points wait while the weights are formed
	always_ff @(posedge clk) begin
		if (en) begin
			pts_s1 <= pts;
			pts_s2 <= pts_s1;
			pts_s3 <= pts_s2;
			pts_s4 <= pts_s3;
		end
	end

	// stage 5: four products
	always_ff @(posedge clk) begin
		if (en) begin
			prod0_s5 <= PROD_W'(pts_s4.p0) * PROD_W'(wgt.w1);
			prod1_s5 <= PROD_W'(pts_s4.p1) * PROD_W'(wgt.w2);
			prod2_s5 <= PROD_W'(pts_s4.p2) * PROD_W'(wgt.w3);
			prod3_s5 <= PROD_W'(pts_s4.p3) * PROD_W'(wgt.w4);
		end
	end

	// stage 6: sum with rounding offset
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s6 <= ACC_W'(prod0_s5) + ACC_W'(prod1_s5)
				+ ACC_W'(prod2_s5) + ACC_W'(prod3_s5) + ROUND;
		end
	end

	// floor shift drops the doubling and the fraction
	assign shifted = acc_s6 >>> (PARAM_FRAC_BITS + 1);

	// stage 7: saturate to coordinate range
	always_ff @(posedge clk) begin
		if (en) begin
			if (shifted > SAT_HI) begin
				res_s7 <= SAT_HI[COORD_BITS-1:0];
			end else if (shifted < SAT_LO) begin
				res_s7 <= SAT_LO[COORD_BITS-1:0];
			end else begin
				res_s7 <= shifted[COORD_BITS-1:0];
			end
		end
	end

	assign res = res_s7;

endmodule

// File: src/catmull_rom_interpolator.sv
// catmull-rom segment evaluator, seven register stages
// an accepted input beat passes stages s1 to s7 in order before it leaves as an output beat
// throughput: one beat per cycle; the whole pipeline holds when the output stalls
// reset: arst_n clears all stage valid bits; payload registers are not reset
// depends on crm_pkg, crm_weights, crm_blend and catmull_rom_interpolator_assert.svh
`include "catmull_rom_interpolator_assert.svh"
module catmull_rom_interpolator
	import crm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y, param_t
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// point_x, point_y
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready
);

	localparam int PT_BASE = 8 * COORD_BITS;

	logic     pipe_en;
	logic     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [6:0] vld_all;
	coord4_t  pts_x, pts_y;
	weights_t wgt;
	logic signed [COORD_BITS-1:0] point_x, point_y;
	logic signed [WGT_W+1:0] wsum;

	// pipeline advances unless the last stage holds an untaken beat
	assign pipe_en  = !vld_s7 || m_tready;
	assign s_tready = pipe_en;

	// unpack input beat
	assign pts_x.p0 = s_tdata[0*COORD_BITS +: COORD_BITS];
	assign pts_y.p0 = s_tdata[1*COORD_BITS +: COORD_BITS];
	assign pts_x.p1 = s_tdata[2*COORD_BITS +: COORD_BITS];
	assign pts_y.p1 = s_tdata[3*COORD_BITS +: COORD_BITS];
	assign pts_x.p2 = s_tdata[4*COORD_BITS +: COORD_BITS];
	assign pts_y.p2 = s_tdata[5*COORD_BITS +: COORD_BITS];
	assign pts_x.p3 = s_tdata[6*COORD_BITS +: COORD_BITS];
	assign pts_y.p3 = s_tdata[7*COORD_BITS +: COORD_BITS];

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// shared weight pipeline
	crm_weights u_weights (
		.clk (clk),
		.en  (pipe_en),
		.t   (s_tdata[PT_BASE +: PARAM_W]),
		.wgt (wgt)
	);

	// per-axis blends
	crm_blend u_blend_x (
		.clk (clk),
		.en  (pipe_en),
		.pts (pts_x),
		.wgt (wgt),
		.res (point_x)
	);

	crm_blend u_blend_y (
		.clk (clk),
		.en  (pipe_en),
		.pts (pts_y),
		.wgt (wgt),
		.res (point_y)
	);

	// pack output beat
	assign m_tvalid = vld_s7;
	assign m_tdata  = OUT_DATA_W'({point_y, point_x});

	// checks
	assign vld_all = {vld_s7, vld_s6, vld_s5, vld_s4, vld_s3, vld_s2, vld_s1};
	assign wsum    = (WGT_W+2)'(wgt.w1) + (WGT_W+2)'(wgt.w2)
		+ (WGT_W+2)'(wgt.w3) + (WGT_W+2)'(wgt.w4);

	`CRM_ASSERT(a_wgt_sum, clk, arst_n, vld_s4 |-> (wsum == ((WGT_W+2)'(1) << (PARAM_FRAC_BITS + 1))))
	`CRM_ASSERT(a_wgt4_nonpos, clk, arst_n, vld_s4 |-> (wgt.w4[WGT_W-1] || (wgt.w4 == '0)))
	`CRM_ASSERT(a_stall_holds, clk, arst_n, !pipe_en |=> $stable(vld_all))
	`CRM_ASSERT(a_accept_enters, clk, arst_n, (s_tvalid && s_tready) |=> vld_s1)
	`CRM_ASSERT_NEVER(a_no_accept_on_stall, clk, arst_n, s_tready && vld_s7 && !m_tready)

endmodule
